// File: rtl/core/ibal_pkg.sv
`default_nettype none
package ibal_pkg;

	localparam int OUT_PTRS = 5;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_SPACE  = 2'd1;
	localparam logic [1:0] ST_NOT_ALLOC = 2'd2;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_A_RD,
		S_A_LD,
		S_A_PK,
		S_F_RD,
		S_F_CHK,
		S_C_RD,
		S_C_WR,
		S_P_WR,
		S_RESP
	} state_t;

	typedef struct packed {
		logic       cmd;
		logic [2:0] block_count;
		logic [8:0] index_block;
	} req_t;

	typedef struct packed {
		logic [1:0]                status;
		logic [8:0]                given_index;
		logic [OUT_PTRS-1:0][8:0]  data_block;
	} res_t;

endpackage
`default_nettype wire

// File: rtl/core/ibal_if.sv
`default_nettype none
interface ibal_req_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [2:0] block_count;
	logic [8:0] index_block;

	modport source(output valid, output cmd, output block_count, output index_block,
		input ready);
	modport sink(input valid, input cmd, input block_count, input index_block,
		output ready);
endinterface

interface ibal_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [8:0] given_index;
	logic [8:0] data_block_0;
	logic [8:0] data_block_1;
	logic [8:0] data_block_2;
	logic [8:0] data_block_3;
	logic [8:0] data_block_4;

	modport source(output valid, output status, output given_index,
		output data_block_0, output data_block_1, output data_block_2,
		output data_block_3, output data_block_4, input ready);
	modport sink(input valid, input status, input given_index,
		input data_block_0, input data_block_1, input data_block_2,
		input data_block_3, input data_block_4, output ready);
endinterface
`default_nettype wire

// File: rtl/core/ibal_ram.sv
`default_nettype none
module ibal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: rtl/core/ibal_ctrl.sv
`default_nettype none
module ibal_ctrl import ibal_pkg::*; #(
	parameter int NUM_BLOCKS = 512,
	parameter int PTRS_PER_INDEX = 5,
	localparam int WW = (NUM_BLOCKS >= 32) ? 32 : 8,
	localparam int LW = $clog2(WW),
	localparam int NW = (NUM_BLOCKS + WW - 1) / WW,
	localparam int WA = (NW > 1) ? $clog2(NW) : 1,
	localparam int BW = $clog2(NUM_BLOCKS),
	localparam int RW = PTRS_PER_INDEX * BW
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	input  wire req_t          req,
	output logic               req_ready,
	output logic               res_valid,
	output res_t               res,
	input  wire logic          res_take,
	output logic [WA-1:0]      bm_raddr,
	input  wire logic [WW-1:0] bm_rdata,
	output logic               bm_we,
	output logic [WA-1:0]      bm_waddr,
	output logic [WW-1:0]      bm_wdata,
	output logic [BW-1:0]      pt_raddr,
	input  wire logic [RW-1:0] pt_rdata,
	output logic               pt_we,
	output logic [BW-1:0]      pt_waddr,
	output logic [RW-1:0]      pt_wdata
);

	localparam int PW = WA + LW;
	localparam int KW = $clog2(PTRS_PER_INDEX + 1);
	localparam int FW = $clog2(PTRS_PER_INDEX + 2);
	localparam int NR = (PTRS_PER_INDEX < OUT_PTRS) ? PTRS_PER_INDEX : OUT_PTRS;

	state_t st_q, st_d;

	logic [BW-1:0]       c_q;
	logic                cmd_q;
	logic [2:0]          want_q;
	logic [8:0]          idx_q;
	logic [WA-1:0]       w_q;
	logic [WW-1:0]       free_q;
	logic [FW-1:0]       found_q;
	logic [PW-1:0]       pick_q [PTRS_PER_INDEX+1];
	logic [PTRS_PER_INDEX:0] sv_q;
	logic [KW-1:0]       k_q;
	logic                clear_q;
	logic [1:0]          status_q;

	logic [2:0]          want_c;
	logic [FW-1:0]       need_c;
	logic [LW-1:0]       lo_c;
	logic [WW-1:0]       rng_c;
	logic [PW-1:0]       idx_pw;
	logic                idx_ok;
	logic [PTRS_PER_INDEX:0] fsv_c;
	logic [PW-1:0]       fpk_c [PTRS_PER_INDEX+1];
	logic [PW-1:0]       cur_c;
	logic                k_last;
	logic                w_last;
	logic                c_last;
	logic                pick_done;

	assign want_c  = (int'(req.block_count) > PTRS_PER_INDEX) ?
		3'(PTRS_PER_INDEX) : req.block_count;
	assign need_c  = FW'(want_q) + FW'(1);
	assign idx_pw  = PW'(idx_q);
	assign idx_ok  = int'(idx_q) < NUM_BLOCKS;
	assign cur_c   = pick_q[k_q];
	assign k_last  = k_q == KW'(PTRS_PER_INDEX);
	assign w_last  = w_q == WA'(NW - 1);
	assign c_last  = c_q == BW'(NUM_BLOCKS - 1);
	assign pick_done = found_q == need_c;

	always_comb begin
		lo_c = '0;
		for (int i = WW - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				lo_c = LW'(i);
			end
		end
	end

	always_comb begin
		for (int b = 0; b < WW; b++) begin
			rng_c[b] = int'({w_q, LW'(b)}) < NUM_BLOCKS;
		end
	end

	always_comb begin
		logic alive;
		logic [BW-1:0] p;
		alive = 1'b1;
		fsv_c[0] = 1'b1;
		fpk_c[0] = idx_pw;
		for (int j = 0; j < PTRS_PER_INDEX; j++) begin
			p = pt_rdata[j*BW +: BW];
			if (p == '0) begin
				alive = 1'b0;
			end
			fsv_c[j+1] = alive && (int'(p) < NUM_BLOCKS);
			fpk_c[j+1] = PW'(p);
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			S_CLR:   if (c_last) st_d = S_IDLE;
			S_IDLE:  if (req_valid) st_d = (req.cmd == CMD_ALLOC) ? S_A_RD : S_F_RD;
			S_A_RD:  st_d = S_A_LD;
			S_A_LD:  st_d = S_A_PK;
			S_A_PK: begin
				if (pick_done) begin
					st_d = S_C_RD;
				end else if (free_q == '0) begin
					st_d = w_last ? S_RESP : S_A_LD;
				end
			end
			S_F_RD:  st_d = S_F_CHK;
			S_F_CHK: st_d = (idx_ok && bm_rdata[idx_pw[LW-1:0]]) ? S_C_RD : S_RESP;
			S_C_RD: begin
				if (sv_q[k_q]) begin
					st_d = S_C_WR;
				end else if (k_last) begin
					st_d = S_P_WR;
				end
			end
			S_C_WR:  st_d = k_last ? S_P_WR : S_C_RD;
			S_P_WR:  st_d = S_RESP;
			S_RESP:  if (res_take) st_d = S_IDLE;
			default: st_d = S_CLR;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		res_valid = 1'b0;
		bm_raddr  = w_q;
		bm_we     = 1'b0;
		bm_waddr  = cur_c[PW-1:LW];
		bm_wdata  = bm_rdata;
		pt_raddr  = BW'(idx_q);
		pt_we     = 1'b0;
		pt_waddr  = BW'(pick_q[0]);
		pt_wdata  = '0;
		unique case (st_q)
			S_CLR: begin
				bm_we    = int'(c_q) < NW;
				bm_waddr = WA'(c_q);
				bm_wdata = '0;
				pt_we    = 1'b1;
				pt_waddr = c_q;
			end
			S_IDLE:  req_ready = 1'b1;
			S_A_PK:  bm_raddr = WA'(w_q + WA'(1));
			S_F_RD:  bm_raddr = idx_pw[PW-1:LW];
			S_C_RD:  bm_raddr = cur_c[PW-1:LW];
			S_C_WR: begin
				bm_we = 1'b1;
				if (clear_q) begin
					bm_wdata = bm_rdata & ~(WW'(1) << cur_c[LW-1:0]);
				end else begin
					bm_wdata = bm_rdata | (WW'(1) << cur_c[LW-1:0]);
				end
			end
			S_P_WR: begin
				pt_we = 1'b1;
				for (int j = 0; j < PTRS_PER_INDEX; j++) begin
					if (!clear_q && sv_q[j+1]) begin
						pt_wdata[j*BW +: BW] = BW'(pick_q[j+1]);
					end
				end
			end
			S_RESP:  res_valid = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		logic ok;
		ok = (status_q == ST_OK) && (cmd_q == CMD_ALLOC);
		res.status      = status_q;
		res.given_index = ok ? 9'(pick_q[0]) : '0;
		res.data_block  = '0;
		for (int j = 0; j < NR; j++) begin
			if (ok && sv_q[j+1]) begin
				res.data_block[j] = 9'(pick_q[j+1]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR;
			c_q  <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == S_CLR) begin
				c_q <= BW'(c_q + BW'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				cmd_q    <= req.cmd;
				want_q   <= want_c;
				idx_q    <= req.index_block;
				w_q      <= '0;
				found_q  <= '0;
				k_q      <= '0;
				sv_q     <= '0;
				status_q <= ST_OK;
			end
			S_A_LD: free_q <= ~bm_rdata & rng_c;
			S_A_PK: begin
				if (pick_done) begin
					clear_q <= 1'b0;
					for (int j = 0; j <= PTRS_PER_INDEX; j++) begin
						sv_q[j] <= j <= int'(want_q);
					end
				end else if (free_q == '0) begin
					if (w_last) begin
						status_q <= ST_NO_SPACE;
					end
					w_q <= WA'(w_q + WA'(1));
				end else begin
					pick_q[found_q[KW-1:0]] <= {w_q, lo_c};
					free_q[lo_c] <= 1'b0;
					found_q <= FW'(found_q + FW'(1));
				end
			end
			S_F_CHK: begin
				clear_q <= 1'b1;
				if (idx_ok && bm_rdata[idx_pw[LW-1:0]]) begin
					sv_q <= fsv_c;
					for (int j = 0; j <= PTRS_PER_INDEX; j++) begin
						pick_q[j] <= fpk_c[j];
					end
				end else begin
					status_q <= ST_NOT_ALLOC;
				end
			end
			S_C_RD: if (!sv_q[k_q] && !k_last) k_q <= KW'(k_q + KW'(1));
			S_C_WR: if (!k_last) k_q <= KW'(k_q + KW'(1));
			default: ;
		endcase
	end

`ifndef SYNTH
	a_wr_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_C_WR |-> $past(st_q) == S_C_RD)
		else $error("bitmap write without its read");

	a_ok_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_RESP && $past(st_q) != S_RESP && status_q == ST_OK)
		|-> $past(st_q) == S_P_WR)
		else $error("ok result without table write");

	a_clr_full: assert property (@(posedge clk) disable iff (!arst_n)
		($past(st_q) == S_CLR && st_q != S_CLR) |-> $past(c_q) == BW'(NUM_BLOCKS - 1))
		else $error("clearing pass cut short");

	a_req_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_A_RD || st_q == S_F_RD) |-> $past(st_q) == S_IDLE)
		else $error("request started outside idle");
`endif

endmodule
`default_nettype wire

// File: rtl/core/indexed_block_allocator_top.sv
// Indexed block allocator.
// req carries one request: cmd 0 allocates a file of block_count data blocks
// (clamped to the entry size), cmd 1 frees the file whose index block is
// index_block. rsp returns exactly one result per request, in order.
// An allocate takes the lowest free blocks word by word from the bitmap
// (index block first), marks each one used and writes the index entry, or
// reports no space if the bitmap runs out. Bitmap words are 32 bits wide (8
// when NUM_BLOCKS is below 32); the bitmap RAM has one read and one write
// port. A free checks that the index block is in use (else it reports not
// allocated), clears the bitmap bit of the index block and of each block its
// entry names, and zeroes the entry. After reset the block sweeps both
// memories with req.ready low, leaving every block free and every entry zero.
// A finished result sits in an output register; the next request is taken
// while it waits. If rsp stalls, a second result holds inside the core and
// req.ready stays low until the output register drains.
`default_nettype none
module indexed_block_allocator_top import ibal_pkg::*; #(
	parameter int NUM_BLOCKS = 512,
	parameter int PTRS_PER_INDEX = 5
) (
	input wire logic clk,
	input wire logic arst_n,
	ibal_req_if.sink   req,
	ibal_rsp_if.source rsp
);

	localparam int WW = (NUM_BLOCKS >= 32) ? 32 : 8;
	localparam int NW = (NUM_BLOCKS + WW - 1) / WW;
	localparam int WA = (NW > 1) ? $clog2(NW) : 1;
	localparam int BW = $clog2(NUM_BLOCKS);
	localparam int RW = PTRS_PER_INDEX * BW;

	req_t          req_c;
	res_t          res_c;
	res_t          res_q;
	logic          res_valid;
	logic          out_free;
	logic          out_v_q;
	logic [WA-1:0] bm_raddr, bm_waddr;
	logic [WW-1:0] bm_rdata, bm_wdata;
	logic          bm_we;
	logic [BW-1:0] pt_raddr, pt_waddr;
	logic [RW-1:0] pt_rdata, pt_wdata;
	logic          pt_we;

	assign req_c.cmd         = req.cmd;
	assign req_c.block_count = req.block_count;
	assign req_c.index_block = req.index_block;
	assign out_free          = !out_v_q || rsp.ready;

	ibal_ctrl #(
		.NUM_BLOCKS(NUM_BLOCKS),
		.PTRS_PER_INDEX(PTRS_PER_INDEX)
	) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req.valid), .req(req_c), .req_ready(req.ready),
		.res_valid(res_valid), .res(res_c), .res_take(out_free),
		.bm_raddr(bm_raddr), .bm_rdata(bm_rdata), .bm_we(bm_we),
		.bm_waddr(bm_waddr), .bm_wdata(bm_wdata),
		.pt_raddr(pt_raddr), .pt_rdata(pt_rdata), .pt_we(pt_we),
		.pt_waddr(pt_waddr), .pt_wdata(pt_wdata)
	);

	ibal_ram #(.WIDTH(WW), .DEPTH(NW)) u_bitmap (
		.clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
		.raddr(bm_raddr), .rdata(bm_rdata)
	);

	ibal_ram #(.WIDTH(RW), .DEPTH(NUM_BLOCKS)) u_table (
		.clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
		.raddr(pt_raddr), .rdata(pt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && out_free) begin
			res_q <= res_c;
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.status       = res_q.status;
	assign rsp.given_index  = res_q.given_index;
	assign rsp.data_block_0 = res_q.data_block[0];
	assign rsp.data_block_1 = res_q.data_block[1];
	assign rsp.data_block_2 = res_q.data_block[2];
	assign rsp.data_block_3 = res_q.data_block[3];
	assign rsp.data_block_4 = res_q.data_block[4];

endmodule
`default_nettype wire
